/* sv/rip_pkg.sv */
// ----------------------------------------------------------------------------
// rip_pkg: shared types and constants of the radix integer parser.
// Holds the item structs, the parse state record, phase and status codes.
// ----------------------------------------------------------------------------
package rip_pkg;

    localparam int COUNT_W = 16;

    typedef logic [COUNT_W-1:0] t_count;

    typedef enum logic [2:0] {
        PH_SPACE,
        PH_SIGNED,
        PH_LEADZERO,
        PH_DIGITS,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_DIGIT = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_BAD_RADIX = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] char_in;
        logic       start_req;
    } t_in_item;

    typedef struct packed {
        logic [63:0] value;
        t_count      consumed;
        logic [1:0]  status;
    } t_out_item;

    typedef struct packed {
        t_phase      phase;
        logic [63:0] acc;
        logic        negative;
        logic        seen_digit;
        logic        overflowed;
        logic [5:0]  eff_radix;
        t_count      char_count;
        t_count      end_count;
    } t_parse;

    localparam t_parse PARSE_CLEAR = '{
        phase:      PH_SPACE,
        acc:        64'd0,
        negative:   1'b0,
        seen_digit: 1'b0,
        overflowed: 1'b0,
        eff_radix:  6'd0,
        char_count: '0,
        end_count:  '0
    };

    localparam logic [5:0] RADIX_RESET = 6'd10;

endpackage

/* sv/radix_integer_parser_core.sv */
// ----------------------------------------------------------------------------
// radix_integer_parser_core: streaming unsigned 64-bit parser, radix 0 (automatic) or 2..36.
// Path: a character enters the input register, and its result leaves from the result register.
// Throughput: one character per cycle unless the result side stalls; the step
// logic (one 64 by 6 bit multiply-add and its carry check) sets the clock period.
// Reset: synchronous, active low; empties both registers, radix returns to 10.
// ----------------------------------------------------------------------------
module radix_integer_parser_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [5:0]         i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rip_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rip_pkg::t_out_item o_out_item
);
    import rip_pkg::*;

    // Input register: holds one accepted character until the step logic
    // can take it. The step fires whenever the result register is free or
    // is being emptied in the same cycle, so a full pipe still moves one
    // item per cycle.
    logic      r_in_vld;
    t_in_item  r_in;
    logic      step_go;

    // Parse state carried from one character to the next.
    t_parse    r_state;
    t_parse    n_state;
    logic      step_emit;
    t_out_item step_result;

    // Radix register, sampled by the step logic while skipping whitespace.
    logic [5:0] r_radix;

    // Result register.
    logic      r_out_vld;
    t_out_item r_out;

    assign step_go    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || step_go;

    rip_step u_step (
        .i_state  (r_state),
        .i_item   (r_in),
        .i_radix  (r_radix),
        .o_state  (n_state),
        .o_emit   (step_emit),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= PARSE_CLEAR;
            r_radix   <= RADIX_RESET;
        end else begin
            if (i_cfg_we) begin
                r_radix <= i_cfg_wdata;
            end

            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end

            if (step_go) begin
                r_state <= n_state;
            end

            // A new result loads only into an empty or draining register.
            if (step_go && step_emit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end

        // Payload registers need no reset.
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
        if (step_go && step_emit) begin
            r_out <= step_result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    // An invalid radix ends the parse with nothing consumed.
    a_bad_radix_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.status == ST_BAD_RADIX) |-> (r_out.value == 64'd0
            && r_out.consumed == '0))
        else $error("invalid radix result carries a value or a count");

    // A parse without digits reports zero and consumes nothing.
    a_no_digit_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.status == ST_NO_DIGIT) |-> (r_out.value == 64'd0
            && r_out.consumed == '0))
        else $error("no-digit result carries a value or a count");

    // Overflow saturates the value and always counts at least one digit.
    a_overflow_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.status == ST_OVERFLOW) |-> (r_out.value == '1
            && r_out.consumed != '0))
        else $error("overflow result is not saturated");

    // The input register only stalls while it holds an item.
    a_stall_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_vld && r_out_vld && !i_out_ready))
        else $error("input stalled without a blocked item");

endmodule

/* sv/rip_step.sv */
// ----------------------------------------------------------------------------
// rip_step: one character step of the parser.
// Computes the next parse state and, when the parse ends, the result item.
// ----------------------------------------------------------------------------
module rip_step (
    input  rip_pkg::t_parse    i_state,
    input  rip_pkg::t_in_item  i_item,
    input  logic [5:0]         i_radix,
    output rip_pkg::t_parse    o_state,
    output logic               o_emit,
    output rip_pkg::t_out_item o_result
);
    import rip_pkg::*;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] UPPER_OFS = 8'h37;
    localparam logic [7:0] LOWER_OFS = 8'h57;
    localparam logic [5:0] RADIX_MAX = 6'd36;
    localparam logic [5:0] RADIX_OCT = 6'd8;
    localparam logic [5:0] RADIX_DEC = 6'd10;
    localparam logic [5:0] RADIX_HEX = 6'd16;

    // Digit value of a character; RADIX_MAX marks a non-digit.
    function automatic logic [5:0] digit_of(input logic [7:0] c);
        logic [5:0] d;
        d = RADIX_MAX;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = 6'(c - CH_ZERO);
        end else if (c >= CH_UA && c <= CH_UZ) begin
            d = 6'(c - UPPER_OFS);
        end else if (c >= CH_LA && c <= CH_LZ) begin
            d = 6'(c - LOWER_OFS);
        end
        return d;
    endfunction

    function automatic t_count bump(input t_count n);
        return (n == '1) ? n : t_count'(n + 1'b1);
    endfunction

    t_parse      s;
    t_parse      ns;
    logic [7:0]  c;
    logic [5:0]  dg;
    logic        is_space;
    logic        do_after;
    logic        do_take;
    logic [69:0] prod;

    always_comb begin
        s        = i_item.start_req ? PARSE_CLEAR : i_state;
        ns       = s;
        c        = i_item.char_in;
        dg       = digit_of(c);
        is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        do_after = 1'b0;
        do_take  = 1'b0;
        prod     = '0;
        o_emit   = 1'b0;
        o_result = '{value: 64'd0, consumed: '0, status: ST_OK};

        case (s.phase)
            PH_SPACE: begin
                ns.eff_radix = i_radix;
                if (i_radix == 6'd1 || i_radix > RADIX_MAX) begin
                    o_emit   = 1'b1;
                    o_result = '{value: 64'd0, consumed: '0, status: ST_BAD_RADIX};
                    ns.phase = PH_DONE;
                end else if (is_space) begin
                    ns.char_count = bump(ns.char_count);
                end else if (c == CH_MINUS || c == CH_PLUS) begin
                    ns.negative   = (c == CH_MINUS);
                    ns.char_count = bump(ns.char_count);
                    ns.phase      = PH_SIGNED;
                end else begin
                    do_after = 1'b1;
                end
            end
            PH_SIGNED: begin
                do_after = 1'b1;
            end
            PH_LEADZERO: begin
                if (c == CH_LX || c == CH_UX) begin
                    ns.char_count = bump(ns.char_count);
                    ns.eff_radix  = RADIX_HEX;
                    ns.phase      = PH_DIGITS;
                end else begin
                    if (ns.eff_radix == 6'd0) begin
                        ns.eff_radix = RADIX_OCT;
                    end
                    do_take = 1'b1;
                end
            end
            PH_DIGITS: begin
                do_take = 1'b1;
            end
            default: begin
            end
        endcase

        // A leading zero may open an octal or hex prefix.
        if (do_after) begin
            if (c == CH_ZERO && (ns.eff_radix == 6'd0 || ns.eff_radix == RADIX_HEX)) begin
                ns.char_count = bump(ns.char_count);
                ns.seen_digit = 1'b1;
                ns.acc        = 64'd0;
                ns.end_count  = ns.char_count;
                ns.phase      = PH_LEADZERO;
            end else begin
                if (ns.eff_radix == 6'd0) begin
                    ns.eff_radix = RADIX_DEC;
                end
                do_take = 1'b1;
            end
        end

        if (do_take) begin
            ns.phase = PH_DIGITS;
            if (dg >= ns.eff_radix) begin
                o_emit   = 1'b1;
                ns.phase = PH_DONE;
                if (ns.overflowed) begin
                    o_result = '{value: '1, consumed: ns.end_count, status: ST_OVERFLOW};
                end else if (!ns.seen_digit) begin
                    o_result = '{value: 64'd0, consumed: '0, status: ST_NO_DIGIT};
                end else begin
                    o_result = '{value: ns.negative ? 64'(-ns.acc) : ns.acc,
                                 consumed: ns.end_count, status: ST_OK};
                end
            end else begin
                ns.char_count = bump(ns.char_count);
                ns.seen_digit = 1'b1;
                ns.end_count  = ns.char_count;
                if (!ns.overflowed) begin
                    // Any bit above bit 63 of acc * radix + digit means overflow.
                    prod = ns.acc * ns.eff_radix + 70'(dg);
                    if (prod[69:64] != 6'd0) begin
                        ns.overflowed = 1'b1;
                        ns.acc        = '1;
                    end else begin
                        ns.acc = prod[63:0];
                    end
                end
            end
        end

        o_state = ns;
    end

endmodule

/* sim/rip_parse_checker.sv */
// ----------------------------------------------------------------------------
// rip_parse_checker: scoreboard for the radix integer parser.
// Watches both channels and the radix write port. It keeps its own parse
// state and radix copy, predicts each parse result from the accepted items,
// and compares each result that the block hands out, field by field.
// ----------------------------------------------------------------------------
module rip_parse_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [5:0]         i_cfg_wdata,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  rip_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  rip_pkg::t_out_item i_out_item,
    output int                 o_pending,
    output int                 o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import rip_pkg::*;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;

    localparam logic [5:0] RADIX_AUTO    = 6'd0;
    localparam logic [5:0] MIN_RADIX     = 6'd2;
    localparam logic [5:0] RADIX_OCTAL   = 6'd8;
    localparam logic [5:0] RADIX_DECIMAL = 6'd10;
    localparam logic [5:0] RADIX_HEX     = 6'd16;
    localparam logic [5:0] MAX_RADIX     = 6'd36;
    localparam logic [5:0] NOT_A_DIGIT   = 6'd36;
    localparam int         REPORT_LIMIT  = 10;

    t_phase      parse_phase;
    logic [63:0] acc;
    logic        negative;
    logic        seen_digit;
    logic        overflowed;
    logic [5:0]  eff_radix;
    logic [5:0]  radix_cfg;
    t_count      char_count;
    t_count      end_count;
    t_out_item   parse_results_q[$];

    function automatic logic [5:0] digit_value(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return 6'(c - CH_ZERO);
        if (c >= CH_UP_A && c <= CH_UP_Z) return 6'(c - CH_UP_A + 8'd10);
        if (c >= CH_LO_A && c <= CH_LO_Z) return 6'(c - CH_LO_A + 8'd10);
        return NOT_A_DIGIT;
    endfunction

    function automatic t_count count_up(input t_count n);
        return (&n) ? n : n + 1'b1;
    endfunction

    task clear_parse();
        parse_phase = PH_SPACE;
        acc         = '0;
        negative    = 1'b0;
        seen_digit  = 1'b0;
        overflowed  = 1'b0;
        eff_radix   = RADIX_AUTO;
        char_count  = '0;
        end_count   = '0;
    endtask

    task post_result(input logic [63:0] v, input t_count n, input t_status s);
        t_out_item r;
        r.value    = v;
        r.consumed = n;
        r.status   = s;
        parse_results_q.push_back(r);
        parse_phase = PH_DONE;
    endtask

    task close_parse();
        if (overflowed) begin
            post_result('1, end_count, ST_OVERFLOW);
        end else if (!seen_digit) begin
            post_result('0, '0, ST_NO_DIGIT);
        end else begin
            post_result(negative ? 64'd0 - acc : acc, end_count, ST_OK);
        end
    endtask

    task take_digit(input logic [7:0] c);
        logic [5:0]  d;
        logic [71:0] wide;
        d = digit_value(c);
        parse_phase = PH_DIGITS;
        if (d >= eff_radix) begin
            close_parse();
        end else begin
            char_count = count_up(char_count);
            seen_digit = 1'b1;
            end_count  = char_count;
            if (!overflowed) begin
                // Any carry out of 64 bits means the value no longer fits.
                wide = {8'd0, acc} * {66'd0, eff_radix} + {66'd0, d};
                if (wide[71:64] != 0) begin
                    overflowed = 1'b1;
                    acc        = '1;
                end else begin
                    acc = wide[63:0];
                end
            end
        end
    endtask

    task after_sign(input logic [7:0] c);
        if (c == CH_ZERO && (eff_radix == RADIX_AUTO || eff_radix == RADIX_HEX)) begin
            char_count  = count_up(char_count);
            seen_digit  = 1'b1;
            acc         = '0;
            end_count   = char_count;
            parse_phase = PH_LEADZERO;
        end else begin
            if (eff_radix == RADIX_AUTO) eff_radix = RADIX_DECIMAL;
            take_digit(c);
        end
    endtask

    task parse_char(input logic [7:0] c, input logic first);
        if (first) clear_parse();
        case (parse_phase)
            PH_SPACE: begin
                eff_radix = radix_cfg;
                if ((eff_radix < MIN_RADIX && eff_radix != RADIX_AUTO) || eff_radix > MAX_RADIX) begin
                    post_result('0, '0, ST_BAD_RADIX);
                end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
                    char_count = count_up(char_count);
                end else if (c == CH_MINUS || c == CH_PLUS) begin
                    negative    = (c == CH_MINUS);
                    char_count  = count_up(char_count);
                    parse_phase = PH_SIGNED;
                end else begin
                    after_sign(c);
                end
            end
            PH_SIGNED: begin
                after_sign(c);
            end
            PH_LEADZERO: begin
                if (c == CH_LO_X || c == CH_UP_X) begin
                    char_count  = count_up(char_count);
                    eff_radix   = RADIX_HEX;
                    parse_phase = PH_DIGITS;
                end else begin
                    if (eff_radix == RADIX_AUTO) eff_radix = RADIX_OCTAL;
                    take_digit(c);
                end
            end
            PH_DIGITS: begin
                take_digit(c);
            end
            default: begin
            end
        endcase
    endtask

    task check_result(input t_out_item got);
        t_out_item want;
        if (parse_results_q.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= REPORT_LIMIT) begin
                $display("%0t: unexpected result value %h consumed %0d status %0d",
                         $time, got.value, got.consumed, got.status);
            end
        end else begin
            want = parse_results_q.pop_front();
            if (got.value !== want.value || got.consumed !== want.consumed ||
                got.status !== want.status) begin
                o_fail_count++;
                if (o_fail_count <= REPORT_LIMIT) begin
                    $display("%0t: result mismatch, expected value %h consumed %0d status %0d",
                             $time, want.value, want.consumed, want.status);
                    $display("%0t:                  got value %h consumed %0d status %0d",
                             $time, got.value, got.consumed, got.status);
                end
            end
        end
    endtask

    // The result leaves before the new item is predicted: a result can never
    // belong to an item accepted at the same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parse();
            radix_cfg = RADIX_DECIMAL;
            parse_results_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) check_result(i_out_item);
            if (i_in_valid && i_in_ready) parse_char(i_in_item.char_in, i_in_item.start_req);
            if (i_cfg_we) radix_cfg = i_cfg_wdata;
        end
        o_pending = parse_results_q.size();
    end

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: top level for the radix integer parser.
// Drives reset, radix writes and character items with random gaps, stalls
// the result side at random, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import rip_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 3;
    // The limit must cover the slowest correct run: every item may wait behind
    // a random input gap and a random result stall, plus the drain before
    // every radix change.
    localparam int CYCLE_LIMIT   = 200000;
    // The answer to the ending character passes the input and result registers;
    // the drain also covers items still in flight that produce no result.
    localparam int DRAIN_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 200;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_X  = 8'h78;

    localparam logic [5:0] RADIX_AUTO  = 6'd0;
    localparam logic [5:0] RADIX_ONE   = 6'd1;
    localparam logic [5:0] RADIX_HEX   = 6'd16;
    localparam logic [5:0] MAX_RADIX   = 6'd36;
    localparam logic [5:0] RADIX_FIELD = 6'd63;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [5:0] cfg_wdata = RADIX_RESET;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    t_in_item   in_item   = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out_item  out_item;

    int pending;
    int fail_count;
    int cycle_count = 0;
    int out_hold    = 0;
    int out_draw;
    int items_sent  = 0;
    bit idle_on     = 1'b1;

    // Characters of the string being built by the random generator.
    logic [7:0] text_q[$];

    radix_integer_parser_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    rip_parse_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Watchdog: a hang or a lost result ends the run here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: after every accepted result the receiver draws a random stall,
    // possibly none, during which ready stays low. When idling is switched
    // off, ready simply stays high.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            out_hold  <= 0;
        end else if (out_hold != 0) begin
            out_hold <= out_hold - 1;
        end else if (!out_ready) begin
            out_ready <= 1'b1;
        end else if (out_valid) begin
            out_draw = idle_on ? $urandom_range(0, 3) : 0;
            if (out_draw != 0) begin
                out_ready <= 1'b0;
                out_hold  <= out_draw - 1;
            end
        end
    end

    // Presents one character item after a random gap and returns at the edge
    // where it is accepted. Valid is left high; the next call either replaces
    // the payload at once or drops valid for its own gap.
    task automatic send_item(input logic [7:0] ch, input logic first);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{char_in: ch, start_req: first};
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_text(input string s, input logic first, input logic [7:0] term);
        int i;
        for (i = 0; i < s.len(); i++) send_item(s[i], first && i == 0);
        send_item(term, 1'b0);
    endtask

    // The radix only changes while the block is idle: the sender stops, every
    // predicted result has to come back, and the pipeline gets time to drain
    // items that end nothing. This is also the pause that lets the result
    // queue run completely empty between phases.
    task automatic set_radix(input logic [5:0] r);
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= r;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] digit_char(input int d, input bit upper);
        if (d < 10) return 8'(CH_ZERO + d);
        return 8'((upper ? CH_UP_A : CH_LO_A) + d - 10);
    endfunction

    // Appends v written in the given base, digits in mixed case.
    task automatic push_number(input logic [63:0] v, input int base);
        logic [7:0] rev[$];
        if (v == 0) rev.push_back(CH_ZERO);
        while (v != 0) begin
            rev.push_back(digit_char(int'(v % base), 1'($urandom_range(0, 1))));
            v = v / base;
        end
        while (rev.size() != 0) text_q.push_back(rev.pop_back());
    endtask

    // Builds and sends one string for the current radix. Most strings are
    // well formed: whitespace, a sign, a prefix where the radix allows one,
    // a number and a terminator. The number is often chosen right at the
    // 64-bit limit so that saturation is hit from both sides. About one
    // string in eight is raw noise with random start flags.
    task automatic send_random_string(input logic [5:0] r);
        int         base;
        int         i;
        int         n;
        int         d;
        logic [63:0] v;
        text_q.delete();
        if ($urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++) begin
                send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
            items_sent += n;
            return;
        end
        base = int'(r);
        repeat ($urandom_range(0, 2)) begin
            if ($urandom_range(0, 1)) text_q.push_back(CH_SPACE);
            else text_q.push_back(8'($urandom_range(CH_TAB, CH_CR)));
        end
        case ($urandom_range(0, 2))
            1: text_q.push_back(CH_PLUS);
            2: text_q.push_back(CH_MINUS);
            default: begin
            end
        endcase
        if ((r == RADIX_AUTO || r == RADIX_HEX) && $urandom_range(0, 1)) begin
            text_q.push_back(CH_ZERO);
            text_q.push_back($urandom_range(0, 1) ? CH_UP_X : CH_LO_X);
            base = 16;
        end else if (r == RADIX_AUTO) begin
            // A leading zero switches automatic mode to octal.
            if ($urandom_range(0, 2) == 0) begin
                text_q.push_back(CH_ZERO);
                base = 8;
            end else begin
                base = 10;
            end
        end
        // With an invalid radix the content never matters.
        if (base < 2 || base > MAX_RADIX) base = 10;
        case ($urandom_range(0, 9))
            0: begin
            end
            1: push_number('1, base);
            2: begin
                push_number('1, base);
                text_q.push_back(digit_char($urandom_range(0, base - 1), 1'b0));
            end
            3: begin
                // One digit past the cutoff: overflows only if it exceeds
                // the remainder of the maximum.
                v = '1;
                push_number(v / base, base);
                d = int'(v % base) + $urandom_range(0, 1);
                if (d < base) text_q.push_back(digit_char(d, 1'b1));
            end
            default: begin
                v = {$urandom, $urandom};
                push_number(v >> $urandom_range(0, 63), base);
            end
        endcase
        case ($urandom_range(0, 3))
            0: text_q.push_back(CH_NUL);
            1: text_q.push_back(8'($urandom_range(0, 255)));
            2: text_q.push_back(CH_DOT);
            default: text_q.push_back(CH_SPACE);
        endcase
        for (i = 0; i < text_q.size(); i++) send_item(text_q[i], i == 0);
        items_sent += text_q.size();
        // Stray bytes after the end of a parse are dropped by the block.
        repeat ($urandom_range(0, 2)) send_item(8'($urandom_range(0, 255)), 1'b0);
    endtask

    initial begin
        int         p;
        logic [5:0] r;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. The first string after reset carries no start flag;
        // it has whitespace and a minus sign. A byte after the result must be
        // ignored, and a lone sign gives no digits.
        send_text(" -7", 1'b0, CH_NUL);
        send_item("9", 1'b0);
        send_text("+", 1'b1, CH_NUL);
        // Automatic radix: a hex prefix without hex digits counts only the
        // zero, and a leading zero followed by 8 stops in octal.
        set_radix(RADIX_AUTO);
        send_text("0x", 1'b1, "g");
        send_text("0", 1'b1, "8");
        // Largest radix, thirteen digits: overflow with saturation.
        set_radix(MAX_RADIX);
        send_text("zzzzzzzzzzzzz", 1'b1, "!");
        // Both kinds of invalid radix end on the very first byte.
        set_radix(RADIX_ONE);
        send_item("5", 1'b1);
        set_radix(RADIX_FIELD);
        send_item("5", 1'b1);

        // Random part, one radix per phase: fixed values first, then a random value
        // of the field and a random valid radix. Some phases run without idling.
        for (p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: r = RADIX_AUTO;
                1: r = MAX_RADIX;
                2: r = 6'd2;
                3: r = RADIX_HEX;
                4: r = RADIX_ONE;
                5: r = 6'd8;
                6: r = RADIX_FIELD;
                7: r = RADIX_RESET;
                8: r = 6'($urandom_range(0, 63));
                default: r = 6'($urandom_range(2, 36));
            endcase
            set_radix(r);
            idle_on    = ($urandom_range(0, 3) != 0);
            items_sent = 0;
            while (items_sent < PHASE_ITEMS) send_random_string(r);
        end
        in_valid <= 1'b0;

        // Wait for the last results, then give the block time to show any
        // result it should not produce.
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/rip_pkg.sv
sv/rip_step.sv
sv/radix_integer_parser_core.sv
sim/rip_parse_checker.sv
sim/testbench.sv
